FILE: sv/odsv_pkg.sv
// Shared types, constants and tables for the oscillator divider solver.
`timescale 1ns / 1ps

package odsv_pkg;

  localparam int unsigned WordW   = 48;
  localparam int unsigned FreqW   = 31;
  localparam int unsigned HsW     = 4;
  localparam int unsigned N1W     = 8;
  localparam int unsigned RfW     = 38;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HnW     = 11;
  localparam int unsigned FhW     = FreqW + HsW;
  localparam int unsigned McW     = FhW + N1W;
  localparam int unsigned RefW    = 28;
  localparam int unsigned DcoW    = 33;
  localparam int unsigned HsIdxW  = 3;

  localparam logic [RefW-1:0] RefHz    = 28'd156250000;
  localparam logic [DcoW-1:0] DcoMinHz = 33'd4850000000;
  localparam logic [DcoW-1:0] DcoMaxHz = 33'd5670000000;
  localparam logic [HsIdxW-1:0] HsLastIdx = 3'd5;

  typedef struct packed {
    logic [WordW-1:0] current_settings;
    logic [FreqW-1:0] requested_freq_hz;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0]   new_settings;
    logic [HsW-1:0]     high_speed_divider;
    logic [N1W-1:0]     output_divider;
    logic [RfW-1:0]     fraction_multiplier;
    logic [StatusW-1:0] status;
  } out_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_ZERO_FREQ,
    ST_NO_FIT,
    ST_RANGE
  } status_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_KEEP1,
    C_KEEP2,
    C_SEARCH,
    C_CALC,
    C_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_LOAD,
    SR_STEP,
    SR_DONE
  } srch_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_PREP1,
    MD_PREP2,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic           done;
    logic           found;
    logic [HsW-1:0] hs;
    logic [N1W-1:0] n1;
  } srch_res_t;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [HsW-1:0]   hs;
    logic [N1W-1:0]   n1;
    logic [HsW-1:0]   hs_old;
    logic [N1W-1:0]   n1_old;
    logic [RfW-1:0]   rf_old;
  } md_req_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [RfW-1:0] q;
  } md_res_t;

  function automatic logic [HsW-1:0] hs_table(logic [HsIdxW-1:0] idx);
    logic [HsW-1:0] v;
    case (idx)
      3'd0:    v = 4'd11;
      3'd1:    v = 4'd9;
      3'd2:    v = 4'd7;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd5;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/oscillator_divider_solver_core.sv
// Top level of the oscillator divider solver: control sequencer and result register.
`timescale 1ns / 1ps

// One transaction takes a 48-bit divider register word and a requested frequency and returns
// one result: the new packed word, the chosen dividers, the new multiplier and a status. The
// block handles one transaction at a time and is not ready while it works. The divider search
// steps through the high-speed dividers in turn with one subtraction per candidate output
// divider, and the new multiplier is then computed by shift-and-add multiplication and
// restoring division on the same shared adder. A zero frequency skips both steps. The
// finished result waits in an output register, and a new transaction is accepted while it
// waits.
module oscillator_divider_solver_core import odsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned KpW = McW;

  ctrl_state_e      state_q, state_d;
  status_e          status_q, status_d;
  logic [WordW-1:0] word_q, word_d;
  logic [FreqW-1:0] freq_q, freq_d;
  logic [FhW-1:0]   kp1_q, kp1_d;
  logic [HsW-1:0]   hs_q, hs_d;
  logic [N1W-1:0]   n1_q, n1_d;
  logic [RfW-1:0]   rf_q, rf_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             load_out;
  logic             srch_start, md_start;
  srch_res_t        srch_res;
  md_req_t          md_req;
  md_res_t          md_res;
  logic [HsW-1:0]   hs_old;
  logic [N1W-1:0]   n1_old;
  logic [RfW-1:0]   rf_old;
  logic [KpW-1:0]   kprod;
  logic             keep;

  assign hs_old = {1'b0, word_q[47:45]} + 4'd4;
  assign n1_old = {1'b0, word_q[44:38]} + 8'd1;
  assign rf_old = word_q[RfW-1:0];
  assign kprod  = KpW'(kp1_q) * KpW'(n1_old);
  assign keep   = (kprod >= KpW'(DcoMinHz)) && (kprod <= KpW'(DcoMaxHz));

  assign md_req.freq   = freq_q;
  assign md_req.hs     = hs_q;
  assign md_req.n1     = n1_q;
  assign md_req.hs_old = hs_old;
  assign md_req.n1_old = n1_old;
  assign md_req.rf_old = rf_old;

  odsv_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .freq_i  (freq_q),
    .res_o   (srch_res)
  );

  odsv_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .req_i   (md_req),
    .res_o   (md_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    freq_q <= freq_d;
    kp1_q  <= kp1_d;
    hs_q   <= hs_d;
    n1_q   <= n1_d;
    rf_q   <= rf_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    word_d     = word_q;
    freq_d     = freq_q;
    kp1_d      = kp1_q;
    hs_d       = hs_q;
    n1_d       = n1_q;
    rf_d       = rf_q;
    srch_start = 1'b0;
    md_start   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          word_d   = in_data_i.current_settings;
          freq_d   = in_data_i.requested_freq_hz;
          status_d = ST_OK;
          state_d  = C_KEEP1;
        end
      end
      C_KEEP1: begin
        kp1_d   = FhW'(freq_q) * FhW'(hs_old);
        state_d = C_KEEP2;
      end
      C_KEEP2: begin
        if (freq_q == '0) begin
          status_d = ST_ZERO_FREQ;
          state_d  = C_FINISH;
        end else if (keep) begin
          hs_d = hs_old;
          n1_d = n1_old;
          if (rf_old == '0) begin
            status_d = ST_RANGE;
            state_d  = C_FINISH;
          end else begin
            md_start = 1'b1;
            state_d  = C_CALC;
          end
        end else begin
          srch_start = 1'b1;
          state_d    = C_SEARCH;
        end
      end
      C_SEARCH: begin
        if (srch_res.done) begin
          if (!srch_res.found) begin
            status_d = ST_NO_FIT;
            state_d  = C_FINISH;
          end else begin
            hs_d = srch_res.hs;
            n1_d = srch_res.n1;
            if (rf_old == '0) begin
              status_d = ST_RANGE;
              state_d  = C_FINISH;
            end else begin
              md_start = 1'b1;
              state_d  = C_CALC;
            end
          end
        end
      end
      C_CALC: begin
        if (md_res.done) begin
          rf_d     = md_res.q;
          status_d = md_res.ovf ? ST_RANGE : ST_OK;
          state_d  = C_FINISH;
        end
      end
      C_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (load_out) begin
      if (status_q != ST_OK) begin
        out_d.new_settings        = word_q;
        out_d.high_speed_divider  = hs_old;
        out_d.output_divider      = n1_old;
        out_d.fraction_multiplier = rf_old;
      end else begin
        out_d.new_settings        = {3'(hs_q - 4'd4), 7'(n1_q - 8'd1), rf_q};
        out_d.high_speed_divider  = hs_q;
        out_d.output_divider      = n1_q;
        out_d.fraction_multiplier = rf_q;
      end
      out_d.status = status_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_ready_o  = (state_q == C_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The multiplier and divider report completion only while the sequencer waits for it.
  a_md_done_in_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_res.done |-> state_q == C_CALC)
    else $error("multiplier and divider finished outside the calculation phase");

  // The divider search reports completion only while the sequencer waits for it.
  a_srch_done_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> state_q == C_SEARCH)
    else $error("divider search finished outside the search phase");

  // A successful result always carries dividers within the oscillator's legal ranges.
  a_ok_dividers_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK) |->
      (out_data_o.high_speed_divider >= 4'd4 && out_data_o.high_speed_divider <= 4'd11 &&
       out_data_o.output_divider >= 8'd1 && out_data_o.output_divider <= 8'd128))
    else $error("successful result with an out-of-range divider");

endmodule

FILE: sv/odsv_search.sv
// Sequential search for a high-speed divider and output divider that fit the DCO band.
`timescale 1ns / 1ps

module odsv_search import odsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [FreqW-1:0] freq_i,
  output srch_res_t        res_o
);

  localparam int unsigned AccW = FhW + 7;

  srch_state_e        state_q, state_d;
  logic [HsIdxW-1:0]  idx_q, idx_d;
  logic [FhW-1:0]     p_q, p_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [N1W-1:0]     nv_q, nv_d;
  logic               found_q, found_d;
  logic [FhW-1:0]     prod;
  logic               below, above;
  logic [AccW-1:0]    step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    acc_q <= acc_d;
    nv_q  <= nv_d;
  end

  assign prod  = FhW'(freq_i) * FhW'(hs_table(idx_q));
  assign below = acc_q < AccW'(DcoMinHz);
  assign above = acc_q > AccW'(DcoMaxHz);
  assign step  = (nv_q == 8'd2) ? AccW'(p_q) : AccW'({p_q, 1'b0});

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    p_d     = p_q;
    acc_d   = acc_q;
    nv_d    = nv_q;
    found_d = found_q;
    case (state_q)
      SR_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = SR_LOAD;
        end
      end
      SR_LOAD: begin
        p_d     = prod;
        acc_d   = {prod, 7'b0};
        nv_d    = 8'd128;
        state_d = SR_STEP;
      end
      SR_STEP: begin
        if (below || (above && nv_q == 8'd1)) begin
          if (idx_q == HsLastIdx) begin
            found_d = 1'b0;
            state_d = SR_DONE;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = SR_LOAD;
          end
        end else if (!above) begin
          found_d = 1'b1;
          state_d = SR_DONE;
        end else begin
          acc_d = acc_q - step;
          nv_d  = (nv_q == 8'd2) ? 8'd1 : nv_q - 8'd2;
        end
      end
      SR_DONE: begin
        state_d = SR_IDLE;
      end
      default: begin
        state_d = SR_IDLE;
      end
    endcase
  end

  assign res_o.done  = (state_q == SR_DONE);
  assign res_o.found = found_q;
  assign res_o.hs    = hs_table(idx_q);
  assign res_o.n1    = nv_q;

endmodule

FILE: sv/odsv_muldiv.sv
// Serial multiplier and restoring divider that compute the new frequency multiplier.
`timescale 1ns / 1ps

module odsv_muldiv import odsv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  md_req_t req_i,
  output md_res_t res_o
);

  localparam int unsigned HiW  = McW;
  localparam int unsigned AddW = McW + 1;
  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] MulLast = CntW'(RfW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(HiW + RfW - 1);

  md_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [FhW-1:0]  fh_q, fh_d;
  logic [HnW-1:0]  hn_q, hn_d;
  logic [McW-1:0]  mc_q, mc_d;
  logic [RfW-1:0]  d_q, d_d;
  logic [HiW-1:0]  hi_q, hi_d;
  logic [RfW-1:0]  lo_q, lo_d;
  logic [RfW-1:0]  r_q, r_d;
  logic [RfW-1:0]  quo_q, quo_d;
  logic            ovf_q, ovf_d;
  logic [AddW-1:0] opa, opb;
  logic            cin;
  logic [AddW:0]   sum;
  logic [RfW:0]    rs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fh_q  <= fh_d;
    hn_q  <= hn_d;
    mc_q  <= mc_d;
    d_q   <= d_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    r_q   <= r_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign rs = {r_q, hi_q[HiW-1]};

  always_comb begin
    if (state_q == MD_DIV) begin
      opa = AddW'(rs);
      opb = ~AddW'(d_q);
      cin = 1'b1;
    end else begin
      opa = AddW'(hi_q);
      opb = lo_q[0] ? AddW'(mc_q) : '0;
      cin = 1'b0;
    end
  end

  assign sum = {1'b0, opa} + {1'b0, opb} + (AddW + 1)'(cin);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fh_d    = fh_q;
    hn_d    = hn_q;
    mc_d    = mc_q;
    d_d     = d_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    r_d     = r_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          state_d = MD_PREP1;
        end
      end
      MD_PREP1: begin
        fh_d    = FhW'(req_i.freq) * FhW'(req_i.hs);
        hn_d    = HnW'(12'(req_i.hs_old) * 12'(req_i.n1_old));
        state_d = MD_PREP2;
      end
      MD_PREP2: begin
        mc_d    = McW'(fh_q) * McW'(req_i.n1);
        d_d     = RfW'(39'(RefHz) * 39'(hn_q));
        hi_d    = '0;
        lo_d    = req_i.rf_old;
        cnt_d   = '0;
        state_d = MD_MUL;
      end
      MD_MUL: begin
        hi_d  = sum[AddW-1:1];
        lo_d  = {sum[0], lo_q[RfW-1:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          r_d     = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        hi_d  = {hi_q[HiW-2:0], lo_q[RfW-1]};
        lo_d  = {lo_q[RfW-2:0], 1'b0};
        r_d   = sum[AddW] ? sum[RfW-1:0] : rs[RfW-1:0];
        quo_d = {quo_q[RfW-2:0], sum[AddW]};
        ovf_d = ovf_q | quo_q[RfW-1];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DivLast) begin
          state_d = MD_DONE;
        end
      end
      MD_DONE: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  assign res_o.done = (state_q == MD_DONE);
  assign res_o.ovf  = ovf_q;
  assign res_o.q    = quo_q;

endmodule
